@@ rtl/core/aict_pkg.sv @@
// aict_pkg: shared types, codes and constants of the adaptive idle commit timer.
// No dependencies; used by aict_div5 and adaptive_idle_commit_timer.

package aict_pkg;

  // field widths fixed by the interface
  localparam int TO_W      = 10;  // timeout and clamp registers
  localparam int B8_W      = 8;   // hysteresis, step and margin registers
  localparam int AVG_INT_W = 11;  // integer part of the rhythm average
  localparam int GAP_W     = 11;  // trained gaps never exceed 1200
  localparam int SW_W      = 13;  // signed working width for clamps and steering

  typedef logic [TO_W-1:0]         to_t;
  typedef logic [B8_W-1:0]         b8_t;
  typedef logic signed [SW_W-1:0]  sw_t;

  // input modes
  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_CHECK   = 3'd1;
  localparam logic [2:0] MODE_ACT     = 3'd2;
  localparam logic [2:0] MODE_PRESS   = 3'd3;
  localparam logic [2:0] MODE_RELEASE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_INIT   = 3'd0;
  localparam logic [2:0] REG_MIN    = 3'd1;
  localparam logic [2:0] REG_MAX    = 3'd2;
  localparam logic [2:0] REG_HYST   = 3'd3;
  localparam logic [2:0] REG_STEP   = 3'd4;
  localparam logic [2:0] REG_MARGIN = 3'd5;

  // register reset values
  localparam to_t INIT_RST   = 10'd300;
  localparam to_t MIN_RST    = 10'd120;
  localparam to_t MAX_RST    = 10'd700;
  localparam b8_t HYST_RST   = 8'd20;
  localparam b8_t STEP_RST   = 8'd25;
  localparam b8_t MARGIN_RST = 8'd60;

  // state after reset: timeout clamp(300), seed clamp(300 - 60)
  localparam to_t TO_RST   = 10'd300;
  localparam to_t SEED_RST = 10'd240;

  localparam int  GAP_MIN  = 15;
  localparam int  GAP_MAX  = 1200;
  localparam to_t SEED_MIN = 10'd80;
  localparam to_t SEED_MAX = 10'd500;

  localparam int  DIVISOR  = 5;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // below lo gives lo, otherwise above hi gives hi
  function automatic to_t clamp_to(sw_t v, to_t lo, to_t hi);
    sw_t los;
    sw_t his;
    to_t res;
    los = $signed({3'b000, lo});
    his = $signed({3'b000, hi});
    if (v < los) begin
      res = lo;
    end else if (v > his) begin
      res = hi;
    end else begin
      res = v[TO_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/aict_div5.sv @@
// aict_div5: shared divide-by-five unit, reciprocal multiply with a registered operand and quotient.
// Depends on aict_pkg for the divisor and the status struct.

module aict_div5 #(
  parameter int NUM_W = 21
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUM_W-1:0]      numer,
  output logic [NUM_W-1:0]      quo,
  output aict_pkg::div_stat_t   stat
);

  // floor(x/5) = (x * RECIP) >> SHIFT for every x below 2^NUM_W
  localparam int SHIFT = NUM_W + 2;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) / 64'(aict_pkg::DIVISOR)) + 64'd1;

  logic [NUM_W-1:0]   num_r;
  logic [NUM_W-1:0]   quo_r;
  logic               busy_r;
  logic               done_r;
  logic [NUM_W-1:0]   recip;
  logic [2*NUM_W-1:0] prod;

  assign recip = NUM_W'(RECIP);
  assign prod  = {{NUM_W{1'b0}}, num_r} * {{NUM_W{1'b0}}, recip};

  // operand registered on start, quotient registered from it while busy, done raised with the quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
      if (start) begin
        num_r <= numer;
      end
      if (busy_r) begin
        quo_r <= {2'b00, prod[2*NUM_W-1:SHIFT]};
      end
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ rtl/core/adaptive_idle_commit_timer.sv @@
// Channel   Direction  Handshake              Payload
// in_       in         in_valid / in_ready    in_mode, in_now_ms, in_pending
// out_      out        out_valid / out_ready  out_commit, out_timeout_ms, out_average_ms
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// Untrained items (start, check, press, release, odd modes, gaps outside the window,
// activity while the pedal is held) go from the execute state straight to the output state.
// Trained activity passes twice through the shared divide-by-five unit (average, then
// target) and then steers the timeout before the output state.
// Synchronous reset gives timeout 300 and average 240.0; cfg_ready is always high.
// in_ready is high only when idle; a stalled result holds the sequencer in its output state.

module adaptive_idle_commit_timer #(
  parameter int TIME_BITS     = 32,
  parameter int AVG_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_now_ms,
  input  logic        in_pending,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_commit,
  output logic [9:0]  out_timeout_ms,
  output logic [10:0] out_average_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  localparam int TW = TIME_BITS;
  localparam int F  = AVG_FRAC_BITS;
  localparam int AW = aict_pkg::AVG_INT_W + F;
  localparam int NW = F + 13;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXEC     = 8'b0000_0010,
    S_LOAD     = 8'b0000_0100,
    S_DIV_AVG  = 8'b0000_1000,
    S_TGT_LOAD = 8'b0001_0000,
    S_DIV_TGT  = 8'b0010_0000,
    S_STEER    = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  aict_pkg::to_t init_r, tmin_r, tmax_r;
  aict_pkg::b8_t hyst_r, stepm_r, margin_r;

  // architectural state
  logic [TW-1:0] last_r, ref_r;
  logic          pedal_r;
  aict_pkg::to_t tout_r;
  logic [AW-1:0] avg_r;

  // current transaction
  logic [2:0]                   mode_r;
  logic [TW-1:0]                now_r;
  logic                         pend_r;
  logic                         commit_r;
  logic [aict_pkg::GAP_W-1:0]   gap_r;
  aict_pkg::to_t                tgt_r;

  // result register
  logic          out_valid_r, out_commit_r;
  aict_pkg::to_t out_to_r;
  logic [10:0]   out_avg_r;

  logic [TW-1:0] now_in, gap_act, gap_idle;
  logic          act_ok, idle_hit, out_free;
  aict_pkg::to_t start_to, seed, tgt_clamped, steer_to;
  aict_pkg::sw_t tgt_sum, diff, mag, step, moved;
  logic          no_move;
  logic [NW-1:0] avg_num, tgt_num, div_numer, div_quo;
  logic          div_start;
  aict_pkg::div_stat_t div_stat;

  assign now_in = TW'(in_now_ms);

  // backwards time counts as zero gap
  assign gap_act  = (now_r >= ref_r)  ? (now_r - ref_r)  : '0;
  assign gap_idle = (now_r >= last_r) ? (now_r - last_r) : '0;
  assign act_ok   = !pedal_r && (gap_act >= TW'(aict_pkg::GAP_MIN))
                    && (gap_act <= TW'(aict_pkg::GAP_MAX));
  assign idle_hit = !pedal_r && pend_r && (gap_idle >= TW'(tout_r));

  assign start_to = aict_pkg::clamp_to($signed({3'b000, init_r}), tmin_r, tmax_r);
  assign seed     = aict_pkg::clamp_to($signed({3'b000, start_to}) - $signed({5'b0, margin_r}),
                                       aict_pkg::SEED_MIN, aict_pkg::SEED_MAX);

  // average update: (gap*2^F + 4*avg + 2) / 5; target: floor(avg / 2^(F-3)) / 5
  assign avg_num   = (NW'(gap_r) << F) + (NW'(avg_r) << 2) + NW'(2);
  assign tgt_num   = NW'(avg_r >> (F - 3));
  assign div_start = (state_r == S_LOAD) || (state_r == S_TGT_LOAD);
  assign div_numer = (state_r == S_TGT_LOAD) ? tgt_num : avg_num;

  aict_div5 #(.NUM_W(NW)) u_div5 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign tgt_sum     = $signed({2'b00, div_quo[aict_pkg::AVG_INT_W-1:0]})
                       + $signed({5'b0, margin_r});
  assign tgt_clamped = aict_pkg::clamp_to(tgt_sum, tmin_r, tmax_r);

  assign diff     = $signed({3'b000, tgt_r}) - $signed({3'b000, tout_r});
  assign mag      = (diff < 0) ? -diff : diff;
  assign no_move  = (mag < $signed({5'b0, hyst_r}));
  assign step     = (mag > $signed({5'b0, stepm_r})) ? $signed({5'b0, stepm_r}) : mag;
  assign moved    = (diff > 0) ? ($signed({3'b000, tout_r}) + step)
                               : ($signed({3'b000, tout_r}) - step);
  assign steer_to = no_move ? tout_r : aict_pkg::clamp_to(moved, tmin_r, tmax_r);

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_EXEC;
      S_EXEC:     state_nxt = (mode_r == aict_pkg::MODE_ACT && act_ok) ? S_LOAD : S_OUT;
      S_LOAD:     state_nxt = S_DIV_AVG;
      S_DIV_AVG:  if (div_stat.done) state_nxt = S_TGT_LOAD;
      S_TGT_LOAD: state_nxt = S_DIV_TGT;
      S_DIV_TGT:  if (div_stat.done) state_nxt = S_STEER;
      S_STEER:    state_nxt = S_OUT;
      S_OUT:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      init_r      <= aict_pkg::INIT_RST;
      tmin_r      <= aict_pkg::MIN_RST;
      tmax_r      <= aict_pkg::MAX_RST;
      hyst_r      <= aict_pkg::HYST_RST;
      stepm_r     <= aict_pkg::STEP_RST;
      margin_r    <= aict_pkg::MARGIN_RST;
      last_r      <= '0;
      ref_r       <= '0;
      pedal_r     <= 1'b0;
      tout_r      <= aict_pkg::TO_RST;
      avg_r       <= {1'b0, aict_pkg::SEED_RST, {F{1'b0}}};
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aict_pkg::REG_INIT:   init_r   <= cfg_wdata;
          aict_pkg::REG_MIN:    tmin_r   <= cfg_wdata;
          aict_pkg::REG_MAX:    tmax_r   <= cfg_wdata;
          aict_pkg::REG_HYST:   hyst_r   <= cfg_wdata[7:0];
          aict_pkg::REG_STEP:   stepm_r  <= cfg_wdata[7:0];
          aict_pkg::REG_MARGIN: margin_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_mode;
            now_r  <= now_in;
            pend_r <= in_pending;
          end
        end
        S_EXEC: begin
          commit_r <= ((mode_r == aict_pkg::MODE_CHECK) && idle_hit)
                      || ((mode_r == aict_pkg::MODE_RELEASE) && pend_r);
          case (mode_r)
            aict_pkg::MODE_START: begin
              tout_r  <= start_to;
              pedal_r <= 1'b0;
              last_r  <= now_r;
              ref_r   <= now_r;
              avg_r   <= {1'b0, seed, {F{1'b0}}};
            end
            aict_pkg::MODE_CHECK: begin
              if (idle_hit) begin
                last_r <= now_r;
              end
            end
            aict_pkg::MODE_ACT: begin
              last_r <= now_r;
              ref_r  <= now_r;
              gap_r  <= gap_act[aict_pkg::GAP_W-1:0];
            end
            aict_pkg::MODE_PRESS: begin
              last_r  <= now_r;
              ref_r   <= now_r;
              pedal_r <= 1'b1;
            end
            aict_pkg::MODE_RELEASE: begin
              last_r  <= now_r;
              ref_r   <= now_r;
              pedal_r <= 1'b0;
            end
            default: ;
          endcase
        end
        S_DIV_AVG: if (div_stat.done) avg_r <= div_quo[AW-1:0];
        S_DIV_TGT: if (div_stat.done) tgt_r <= tgt_clamped;
        S_STEER:   tout_r <= steer_to;
        default: ;
      endcase

      if (state_r == S_OUT && out_free) begin
        out_valid_r  <= 1'b1;
        out_commit_r <= commit_r;
        out_to_r     <= tout_r;
        out_avg_r    <= avg_r[AW-1:F];
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_commit     = out_commit_r;
  assign out_timeout_ms = out_to_r;
  assign out_average_ms = out_avg_r;

  // timeout and average only move while a transaction is being worked on
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !(in_valid && in_ready)) |=> ($stable(tout_r) && $stable(avg_r)))
    else $error("timeout or average changed while idle");

  // the divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV_AVG || state_r == S_DIV_TGT))
    else $error("divider finished outside a divide state");

  // no new transaction while the shared divider is running
  a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !in_ready)
    else $error("input ready while divider busy");

  // a commit only comes from a periodic check or a pedal release
  a_commit_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && commit_r)
      |-> (mode_r == aict_pkg::MODE_CHECK || mode_r == aict_pkg::MODE_RELEASE))
    else $error("commit raised by a mode that cannot commit");

endmodule
